@@ rtl/tlvp_pkg.sv @@
// Shared types and codes for the BER-TLV stream parser.
// Used by the region cell, the region stack and the top level.
package tlvp_pkg;

  localparam logic [1:0] ROLE_TAG    = 2'd0;
  localparam logic [1:0] ROLE_LENGTH = 2'd1;
  localparam logic [1:0] ROLE_VALUE  = 2'd2;
  localparam logic [1:0] ROLE_IGNORE = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_TAG  = 3'd1;
  localparam logic [2:0] ST_BAD_LEN  = 3'd2;
  localparam logic [2:0] ST_OVERRUN  = 3'd3;
  localparam logic [2:0] ST_TRAILING = 3'd4;
  localparam logic [2:0] ST_TOO_DEEP = 3'd5;

  localparam logic [4:0] TAG_MULTI_BYTE = 5'h1F;

  typedef struct packed {
    logic wr;
    logic in_stack;
    logic is_top;
  } tlvp_cell_ctl_t;

  typedef struct packed {
    logic push;
    logic pop_en;
  } tlvp_stk_ctl_t;

endpackage

@@ rtl/tlvp_cell.sv @@
// One region cell: holds the end offset of one open constructed region.
// Depends on tlvp_pkg; chained by tlvp_stack, pop request ripples downward.
module tlvp_cell import tlvp_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  tlvp_cell_ctl_t           ctl,
  input  logic [POSITION_BITS-1:0] wr_end,
  input  logic [POSITION_BITS-1:0] cmp_pos,
  input  logic                     pop_above,
  output logic                     pop,
  output logic [POSITION_BITS-1:0] top_end
);

  logic [POSITION_BITS-1:0] region_end;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      region_end <= wr_end;
    end
  end

  assign pop     = ctl.in_stack && (region_end == cmp_pos) && (ctl.is_top || pop_above);
  assign top_end = ctl.is_top ? region_end : '0;

endmodule

@@ rtl/tlvp_stack.sv @@
// Region stack built as a row of tlvp_cell instances.
// Depends on tlvp_pkg and tlvp_cell; gives the top region end and next depth.
module tlvp_stack import tlvp_pkg::*; #(
  parameter int MAX_DEPTH     = 8,
  parameter int POSITION_BITS = 16,
  localparam int DW           = $clog2(MAX_DEPTH + 1)
) (
  input  logic                     clk,
  input  tlvp_stk_ctl_t            ctl,
  input  logic [DW-1:0]            depth,
  input  logic [POSITION_BITS-1:0] push_end,
  input  logic [POSITION_BITS-1:0] cmp_pos,
  output logic [POSITION_BITS-1:0] top_end,
  output logic [DW-1:0]            depth_next
);

  logic [MAX_DEPTH-1:0]     pops;
  logic [MAX_DEPTH-1:0]     pop_above;
  logic [POSITION_BITS-1:0] cell_top [MAX_DEPTH];
  tlvp_cell_ctl_t           cell_ctl [MAX_DEPTH];
  logic [DW-1:0]            popped;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    assign cell_ctl[i].wr       = ctl.push && (depth == DW'(i));
    assign cell_ctl[i].in_stack = DW'(i) < depth;
    assign cell_ctl[i].is_top   = DW'(i + 1) == depth;
    if (i == MAX_DEPTH - 1) begin : g_last
      assign pop_above[i] = 1'b0;
    end else begin : g_mid
      assign pop_above[i] = pops[i+1];
    end
    tlvp_cell #(.POSITION_BITS(POSITION_BITS)) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .wr_end    (push_end),
      .cmp_pos   (cmp_pos),
      .pop_above (pop_above[i]),
      .pop       (pops[i]),
      .top_end   (cell_top[i])
    );
  end

  always_comb begin
    top_end = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      top_end = top_end | cell_top[i];
    end
  end

  always_comb begin
    popped = depth;
    for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
      if (pops[i]) begin
        popped = DW'(i);
      end
    end
    if (ctl.push) begin
      depth_next = depth + DW'(1);
    end else if (ctl.pop_en) begin
      depth_next = popped;
    end else begin
      depth_next = depth;
    end
  end

endmodule

@@ rtl/ber_tlv_stream_parser_top.sv @@
// BER-TLV stream parser, top level: header state machine and output register.
// Depends on tlvp_pkg and tlvp_stack.
//
// Usage:
//   Input channel (in_valid / in_stall): one buffer byte per word, with first
//   marking the opening byte of a buffer and total_length sampled on it.
//   Output channel (out_valid / out_stall): one result word per input word:
//   byte role, header fields when a header completes, nesting depth, status
//   and a buffer-complete flag.
//   Config channel (cfg_valid / cfg_ready, always ready): writes multi_mode;
//   write it only while the parser is idle.
//   The output is registered. Throughput is one byte per cycle unless a
//   held result stalls the input; each byte is resolved in a single pass
//   against the row of region-end cells, which pop in the same cycle.
//   When out_stall is high and a result is held, in_stall rises and the
//   input word waits; nothing is dropped.
//   Synchronous reset clears control state and the output valid; bytes seen
//   before the first buffer start are reported as ignored.
module ber_tlv_stream_parser_top import tlvp_pkg::*; #(
  parameter int MAX_DEPTH        = 8,
  parameter int MAX_LENGTH_BYTES = 5,
  parameter int POSITION_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first,
  input  logic [15:0] total_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  byte_role,
  output logic        header_done,
  output logic [15:0] tag_number,
  output logic [15:0] value_length,
  output logic        constructed,
  output logic [3:0]  nesting_depth,
  output logic [2:0]  status,
  output logic        buffer_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        multi_mode
);

  localparam int P   = POSITION_BITS;
  localparam int DW  = $clog2(MAX_DEPTH + 1);
  localparam int LW  = 8 * MAX_LENGTH_BYTES;
  localparam int LBW = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int CW  = (LW > P) ? LW : P;

  typedef enum logic [2:0] {
    PH_TAG1,
    PH_TAG2,
    PH_LEN1,
    PH_LENN,
    PH_VALUE
  } phase_t;

  phase_t          phase, phase_next, e_phase;
  logic [P-1:0]    byte_position, pos_next, e_pos;
  logic [P-1:0]    buffer_end, e_end;
  logic [DW-1:0]   stack_depth, e_depth, depth_next;
  logic            error_seen, err_next, e_err;
  logic            top_done, top_done_next, e_top_done;
  logic            mode;
  logic [15:0]     tag_acc, tag_next;
  logic            cons, cons_next;
  logic [LW-1:0]   len_acc, len_acc_next;
  logic [LBW-1:0]  len_left, len_left_next;
  logic [P-1:0]    prim_end, prim_end_next;

  logic            in_acc;
  logic            active;
  logic [P-1:0]    after, region, room, top_end, push_end;
  logic [6:0]      n_len;
  logic            fin, fail, push, pop_en;
  logic [LW-1:0]   fin_len;
  tlvp_stk_ctl_t   stk_ctl;

  logic [1:0]      r_role;
  logic            r_hdr, r_cons, r_done;
  logic [15:0]     r_tag, r_len;
  logic [2:0]      r_status;

  assign in_stall  = out_valid && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign e_end      = first ? P'(total_length) : buffer_end;
  assign e_pos      = first ? '0 : byte_position;
  assign e_phase    = first ? PH_TAG1 : phase;
  assign e_depth    = first ? '0 : stack_depth;
  assign e_err      = first ? 1'b0 : error_seen;
  assign e_top_done = first ? 1'b0 : top_done;

  assign active = !e_err && (e_pos < e_end);
  assign after  = e_pos + P'(1);
  assign region = (e_depth != '0) ? top_end : e_end;
  assign room   = (region > after) ? (region - after) : '0;
  assign n_len  = data_byte[6:0];

  always_comb begin
    phase_next    = e_phase;
    pos_next      = e_pos;
    err_next      = e_err;
    top_done_next = e_top_done;
    tag_next      = tag_acc;
    cons_next     = cons;
    len_acc_next  = len_acc;
    len_left_next = len_left;
    prim_end_next = prim_end;
    fin           = 1'b0;
    fin_len       = '0;
    fail          = 1'b0;
    push          = 1'b0;
    pop_en        = 1'b0;
    push_end      = after + P'(fin_len);
    r_role        = ROLE_IGNORE;
    r_hdr         = 1'b0;
    r_tag         = '0;
    r_len         = '0;
    r_cons        = 1'b0;
    r_status      = ST_OK;
    r_done        = 1'b0;
    if (active) begin
      unique case (e_phase)
        PH_TAG1: begin
          r_role = ROLE_TAG;
          if (e_depth == '0 && e_top_done && !mode) begin
            fail     = 1'b1;
            r_status = ST_TRAILING;
          end else begin
            tag_next  = {8'h00, data_byte};
            cons_next = data_byte[5];
            if (data_byte[4:0] == TAG_MULTI_BYTE) begin
              if (room == '0) begin
                fail     = 1'b1;
                r_status = ST_BAD_TAG;
              end else begin
                phase_next = PH_TAG2;
              end
            end else if (data_byte == 8'h00) begin
              fail     = 1'b1;
              r_status = ST_BAD_TAG;
            end else if (room == '0) begin
              fail     = 1'b1;
              r_status = ST_BAD_LEN;
            end else begin
              phase_next = PH_LEN1;
            end
          end
        end
        PH_TAG2: begin
          r_role   = ROLE_TAG;
          tag_next = {tag_acc[7:0], data_byte};
          if (room == '0) begin
            fail     = 1'b1;
            r_status = ST_BAD_LEN;
          end else begin
            phase_next = PH_LEN1;
          end
        end
        PH_LEN1: begin
          r_role = ROLE_LENGTH;
          if (!data_byte[7]) begin
            fin     = 1'b1;
            fin_len = LW'(n_len);
          end else if (n_len > 7'(MAX_LENGTH_BYTES)) begin
            fail     = 1'b1;
            r_status = ST_BAD_LEN;
          end else if (n_len == 7'd0) begin
            fin = 1'b1;
          end else if (P'(n_len) > room) begin
            fail     = 1'b1;
            r_status = ST_BAD_LEN;
          end else begin
            len_acc_next  = '0;
            len_left_next = LBW'(n_len);
            phase_next    = PH_LENN;
          end
        end
        PH_LENN: begin
          r_role        = ROLE_LENGTH;
          len_acc_next  = (len_acc << 8) | LW'(data_byte);
          len_left_next = len_left - LBW'(1);
          if (len_left_next == '0) begin
            fin     = 1'b1;
            fin_len = len_acc_next;
          end
        end
        default: begin
          r_role = ROLE_VALUE;
          if (after >= prim_end) begin
            phase_next = PH_TAG1;
          end
        end
      endcase

      push_end = after + P'(fin_len);
      if (fin) begin
        if (CW'(fin_len) > CW'(room)) begin
          fail     = 1'b1;
          r_status = ST_OVERRUN;
        end else if (cons_next && fin_len != '0 && e_depth == DW'(MAX_DEPTH)) begin
          fail     = 1'b1;
          r_status = ST_TOO_DEEP;
        end else begin
          if (cons_next && fin_len != '0) begin
            push       = 1'b1;
            phase_next = PH_TAG1;
          end else if (fin_len == '0) begin
            phase_next = PH_TAG1;
          end else begin
            prim_end_next = push_end;
            phase_next    = PH_VALUE;
          end
          if (e_depth == '0) begin
            top_done_next = 1'b1;
          end
          r_hdr  = 1'b1;
          r_tag  = tag_next;
          r_len  = 16'(fin_len);
          r_cons = cons_next;
        end
      end

      if (fail) begin
        err_next = 1'b1;
      end else begin
        pos_next = after;
        pop_en   = (phase_next == PH_TAG1) && !push;
        r_done   = (after == e_end);
      end
    end
  end

  assign stk_ctl.push   = push && in_acc;
  assign stk_ctl.pop_en = pop_en;

  tlvp_stack #(
    .MAX_DEPTH     (MAX_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_stack (
    .clk        (clk),
    .ctl        (stk_ctl),
    .depth      (e_depth),
    .push_end   (push_end),
    .cmp_pos    (after),
    .top_end    (top_end),
    .depth_next (depth_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG1;
      byte_position <= '0;
      buffer_end    <= '0;
      stack_depth   <= '0;
      error_seen    <= 1'b0;
      top_done      <= 1'b0;
      mode          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= multi_mode;
      end
      if (in_acc) begin
        phase         <= phase_next;
        byte_position <= pos_next;
        buffer_end    <= e_end;
        stack_depth   <= depth_next;
        error_seen    <= err_next;
        top_done      <= top_done_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_acc       <= tag_next;
      cons          <= cons_next;
      len_acc       <= len_acc_next;
      len_left      <= len_left_next;
      prim_end      <= prim_end_next;
      byte_role     <= r_role;
      header_done   <= r_hdr;
      tag_number    <= r_tag;
      value_length  <= r_len;
      constructed   <= r_cons;
      nesting_depth <= 4'(e_depth);
      status        <= r_status;
      buffer_done   <= r_done;
    end
  end

endmodule

@@ tb/sv/ber_tlv_stream_parser_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench for ber_tlv_stream_parser_top: a byte-level BER-TLV parse predictor checks every
// result word; directed corner buffers, then random nested buffers. Depends on tlvp_pkg.
module ber_tlv_stream_parser_top_tb;
  import tlvp_pkg::*;

  localparam int DEPTH_LIMIT   = 8;
  localparam int LEN_BYTES_MAX = 5;
  localparam int POS_BITS      = 16;

  typedef logic [7:0] bytes_t[$];

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic [15:0] tl;
  } tlv_word_t;

  typedef struct packed {
    logic [1:0]  role;
    logic        hdr;
    logic [15:0] tag;
    logic [15:0] len;
    logic        cons;
    logic [3:0]  depth;
    logic [2:0]  status;
    logic        done;
  } tlv_result_t;

  typedef enum logic [2:0] {
    HDR_TAG1,
    HDR_TAG2,
    HDR_LEN1,
    HDR_LENN,
    HDR_VALUE
  } hdr_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        first = 1'b0;
  logic [15:0] total_length = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  byte_role;
  logic        header_done;
  logic [15:0] tag_number;
  logic [15:0] value_length;
  logic        constructed;
  logic [3:0]  nesting_depth;
  logic [2:0]  status;
  logic        buffer_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        multi_mode = 1'b0;

  tlv_word_t   byte_q[$];
  tlv_result_t result_q[$];
  int          fail_count = 0;
  bit          taken = 1'b0;
  bit          calm = 1'b0;
  bit          squeeze = 1'b0;
  bit          squeezed = 1'b0;
  int          hold_left = 0;

  // parse state mirrored from the block
  bit          mm = 1'b0;
  hdr_phase_t  hphase = HDR_TAG1;
  logic [15:0] tag_acc = '0;
  logic [39:0] len_acc = '0;
  int          len_left = 0;
  logic [15:0] pos = '0;
  logic [15:0] buf_end = '0;
  logic [15:0] region_end[DEPTH_LIMIT];
  int          depth = 0;
  logic [15:0] pv_end = '0;
  bit          dead = 1'b0;
  bit          top_done = 1'b0;

  ber_tlv_stream_parser_top #(
    .MAX_DEPTH        (DEPTH_LIMIT),
    .MAX_LENGTH_BYTES (LEN_BYTES_MAX),
    .POSITION_BITS    (POS_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .first         (first),
    .total_length  (total_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .byte_role     (byte_role),
    .header_done   (header_done),
    .tag_number    (tag_number),
    .value_length  (value_length),
    .constructed   (constructed),
    .nesting_depth (nesting_depth),
    .status        (status),
    .buffer_done   (buffer_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .multi_mode    (multi_mode)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void close_header(inout tlv_result_t r, input longint unsigned vlen,
                                       input longint unsigned after, input longint unsigned room);
    logic [7:0] lead;
    bit         cons;
    lead = (tag_acc > 16'h00FF) ? tag_acc[15:8] : tag_acc[7:0];
    cons = lead[5];
    if (vlen > room) begin
      r.status = ST_OVERRUN;
      dead = 1'b1;
      return;
    end
    if (cons && vlen != 0) begin
      if (depth >= DEPTH_LIMIT) begin
        r.status = ST_TOO_DEEP;
        dead = 1'b1;
        return;
      end
      region_end[depth] = 16'(after + vlen);
      depth++;
      hphase = HDR_TAG1;
    end else if (vlen == 0) begin
      hphase = HDR_TAG1;
    end else begin
      pv_end = 16'(after + vlen);
      hphase = HDR_VALUE;
    end
    if (depth == 0 || (cons && vlen != 0 && depth == 1)) top_done = 1'b1;
    r.hdr  = 1'b1;
    r.tag  = tag_acc;
    r.len  = vlen[15:0];
    r.cons = cons;
  endfunction

  function automatic tlv_result_t parse_byte(input tlv_word_t w);
    tlv_result_t     r;
    longint unsigned after;
    longint unsigned rgn;
    longint unsigned room;
    int              n;
    r = '0;
    if (w.first) begin
      buf_end  = w.tl;
      pos      = '0;
      hphase   = HDR_TAG1;
      depth    = 0;
      dead     = 1'b0;
      top_done = 1'b0;
      tag_acc  = '0;
      len_acc  = '0;
      len_left = 0;
    end
    r.depth = 4'(depth);
    if (dead || pos >= buf_end) begin
      r.role = ROLE_IGNORE;
    end else begin
      after = longint'(pos) + 1;
      rgn   = (depth > 0) ? region_end[depth - 1] : buf_end;
      room  = (rgn > after) ? rgn - after : 0;
      case (hphase)
        HDR_TAG1: begin
          r.role = ROLE_TAG;
          if (depth == 0 && top_done && !mm) begin
            r.status = ST_TRAILING;
            dead = 1'b1;
          end else begin
            tag_acc = {8'h00, w.data};
            if (w.data[4:0] == TAG_MULTI_BYTE) begin
              if (room == 0) begin
                r.status = ST_BAD_TAG;
                dead = 1'b1;
              end else begin
                hphase = HDR_TAG2;
              end
            end else if (w.data == 8'h00) begin
              r.status = ST_BAD_TAG;
              dead = 1'b1;
            end else if (room == 0) begin
              r.status = ST_BAD_LEN;
              dead = 1'b1;
            end else begin
              hphase = HDR_LEN1;
            end
          end
        end
        HDR_TAG2: begin
          r.role = ROLE_TAG;
          tag_acc = {tag_acc[7:0], w.data};
          if (room == 0) begin
            r.status = ST_BAD_LEN;
            dead = 1'b1;
          end else begin
            hphase = HDR_LEN1;
          end
        end
        HDR_LEN1: begin
          r.role = ROLE_LENGTH;
          if (!w.data[7]) begin
            close_header(r, w.data, after, room);
          end else begin
            n = w.data[6:0];
            if (n > LEN_BYTES_MAX || (n != 0 && n > room)) begin
              r.status = ST_BAD_LEN;
              dead = 1'b1;
            end else if (n == 0) begin
              close_header(r, 0, after, room);
            end else begin
              len_acc  = '0;
              len_left = n;
              hphase   = HDR_LENN;
            end
          end
        end
        HDR_LENN: begin
          r.role = ROLE_LENGTH;
          len_acc = {len_acc[31:0], w.data};
          if (len_left > 0) len_left--;
          if (len_left == 0) close_header(r, len_acc, after, room);
        end
        default: begin
          r.role = ROLE_VALUE;
          if (after >= pv_end) hphase = HDR_TAG1;
        end
      endcase
      if (!dead) begin
        pos = after[15:0];
        while (hphase == HDR_TAG1 && depth > 0 && region_end[depth - 1] == pos) depth--;
        if (pos == buf_end) r.done = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic bytes_t tlv_wrap(input bit cons, input bytes_t body);
    bytes_t     enc;
    logic [7:0] lead;
    int         sz;
    int         nb;
    int         i;
    sz = body.size();
    lead = 8'($urandom_range(0, 255));
    lead[5] = cons;
    if (lead == 8'h00) lead = 8'h01;
    enc.push_back(lead);
    if (lead[4:0] == TAG_MULTI_BYTE) enc.push_back(8'($urandom_range(0, 255)));
    if (sz < 128 && $urandom_range(0, 2) != 0) begin
      enc.push_back(8'(sz));
    end else begin
      nb = 0;
      while ((sz >> (8 * nb)) != 0) nb++;
      nb = $urandom_range(nb, LEN_BYTES_MAX);
      enc.push_back(8'h80 | 8'(nb));
      for (i = nb - 1; i >= 0; i--) enc.push_back(8'(sz >> (8 * i)));
    end
    return {enc, body};
  endfunction

  function automatic bytes_t leaf_element();
    bytes_t val;
    if ($urandom_range(0, 4) == 0) return tlv_wrap(1'b1, val);
    repeat ($urandom_range(0, 6)) val.push_back(8'($urandom_range(0, 255)));
    return tlv_wrap(1'b0, val);
  endfunction

  function automatic bytes_t make_element(input int levels);
    bytes_t body;
    int     i;
    body = leaf_element();
    for (i = 0; i < levels; i++) begin
      if ($urandom_range(0, 2) == 0) body = {leaf_element(), body};
      if ($urandom_range(0, 2) == 0) body = {body, leaf_element()};
      body = tlv_wrap(1'b1, body);
    end
    return body;
  endfunction

  function automatic void add_word(input logic [7:0] d, input logic f, input logic [15:0] tl);
    byte_q.push_back('{data: d, first: f, tl: tl});
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic feed_random(input int target);
    bytes_t enc;
    int     made;
    int     kind;
    int     deep;
    int     ntop;
    int     tl;
    int     i;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 99);
      enc = {};
      if (kind >= 94) begin
        repeat ($urandom_range(1, 8)) enc.push_back(8'($urandom_range(0, 255)));
        tl = $urandom_range(0, 1) ? $urandom_range(0, 10) : $urandom_range(0, 65535);
      end else begin
        deep = (kind >= 88) ? $urandom_range(DEPTH_LIMIT, DEPTH_LIMIT + 1) : 0;
        ntop = (mm || (kind >= 80 && kind < 88)) ? $urandom_range(1, 3) : 1;
        repeat (ntop) enc = {enc, make_element(deep != 0 ? deep : $urandom_range(0, 3))};
        tl = enc.size();
        if (kind >= 70 && kind < 80)
          enc[$urandom_range(0, enc.size() - 1)] = 8'($urandom_range(0, 255));
        if (kind >= 80 && kind < 88 && mm) tl = tl + $urandom_range(0, 4) - 2;
        made += enc.size();
      end
      for (i = 0; i < enc.size(); i++)
        add_word(enc[i], i == 0, (i == 0) ? 16'(tl) : 16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic write_mode(input logic v);
    @(negedge clk);
    cfg_valid  <= 1'b1;
    multi_mode <= v;
    do @(posedge clk); while (!cfg_ready);
    mm = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender: hold a stalled word, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (!rst && (!in_valid || taken)) begin
      if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
        in_valid     <= 1'b1;
        data_byte    <= byte_q[0].data;
        first        <= byte_q[0].first;
        total_length <= byte_q[0].tl;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (squeeze && !squeezed) begin
      squeezed = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && $urandom_range(0, 99) < 33;
    end
  end

  always @(posedge clk) begin
    tlv_result_t want;
    taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result word with no byte pending");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          check_field("byte_role", 16'(want.role), 16'(byte_role));
          check_field("header_done", 16'(want.hdr), 16'(header_done));
          check_field("tag_number", want.tag, tag_number);
          check_field("value_length", want.len, value_length);
          check_field("constructed", 16'(want.cons), 16'(constructed));
          check_field("nesting_depth", 16'(want.depth), 16'(nesting_depth));
          check_field("status", 16'(want.status), 16'(status));
          check_field("buffer_done", 16'(want.done), 16'(buffer_done));
        end
      end
      if (in_valid && !in_stall) begin
        taken = 1'b1;
        result_q.push_back(parse_byte('{data: data_byte, first: first, tl: total_length}));
        void'(byte_q.pop_front());
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_mode(1'b0);

    add_word(8'hAA, 1'b0, 16'h0000);
    add_word(8'h5A, 1'b1, 16'h0000);
    add_word(8'h00, 1'b1, 16'h0004);
    add_word(8'h01, 1'b0, 16'h0000);
    add_word(8'h9F, 1'b1, 16'h0001);
    add_word(8'h5A, 1'b1, 16'h0001);
    add_word(8'h5A, 1'b1, 16'h0005);
    add_word(8'h86, 1'b0, 16'h0000);
    add_word(8'h5A, 1'b1, 16'h0003);
    add_word(8'h83, 1'b0, 16'h0000);
    add_word(8'h5A, 1'b1, 16'h0002);
    add_word(8'h80, 1'b0, 16'h0000);
    add_word(8'hC3, 1'b0, 16'h0000);
    add_word(8'h5A, 1'b1, 16'h0003);
    add_word(8'h05, 1'b0, 16'h0000);
    add_word(8'h5A, 1'b1, 16'h0003);
    add_word(8'h00, 1'b0, 16'h0000);
    add_word(8'h5A, 1'b0, 16'h0000);
    add_word(8'hFF, 1'b1, 16'hFFFF);
    add_word(8'hFF, 1'b0, 16'h0000);
    add_word(8'h85, 1'b0, 16'h0000);
    add_word(8'h00, 1'b0, 16'h0000);
    add_word(8'h00, 1'b0, 16'h0000);
    add_word(8'h00, 1'b0, 16'h0000);
    add_word(8'hFF, 1'b0, 16'h0000);
    add_word(8'hF0, 1'b0, 16'h0000);
    drain();

    write_mode(1'b1);
    feed_random(250);
    drain();

    write_mode(1'b0);
    feed_random(250);
    drain();

    calm = 1'b1;
    write_mode(1'b1);
    feed_random(150);
    drain();
    calm = 1'b0;

    write_mode(1'b0);
    squeeze = 1'b1;
    feed_random(150);
    drain();

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ber_tlv_stream_parser_top_tb passed");
    end else begin
      $display("ber_tlv_stream_parser_top_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ber_tlv_stream_parser_top_tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tlvp_pkg.sv
rtl/tlvp_cell.sv
rtl/tlvp_stack.sv
rtl/ber_tlv_stream_parser_top.sv
tb/sv/ber_tlv_stream_parser_top_tb.sv
